// File: hdl/xxh_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// xxh_pkg
// Shared constants, types and helpers for the streaming xxHash64 engine.
// ---------------------------------------------------------------------------
package xxh_pkg;

    localparam logic [63:0] P1 = 64'h9e3779b185ebca87;
    localparam logic [63:0] P2 = 64'hc2b2ae3d27d4eb4f;
    localparam logic [63:0] P3 = 64'h165667b19e3779f9;
    localparam logic [63:0] P4 = 64'h85ebca77c2b2ae63;
    localparam logic [63:0] P5 = 64'h27d4eb2f165667c5;

    localparam int QUEUE_DEPTH = 2;

    // one classified word as it travels from front to back
    typedef struct packed {
        logic [63:0] data;
        logic [63:0] seed;
        logic [3:0]  cnt;
        logic        last;
        logic        full;
    } t_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LANE_A,
        S_LANE_B,
        S_FIN,
        S_MRG_A,
        S_MRG_B,
        S_MRG_C,
        S_TAIL,
        S_T8_A,
        S_T8_B,
        S_T8_C,
        S_T4_A,
        S_T4_B,
        S_T1_A,
        S_T1_B,
        S_AV_A,
        S_AV_B,
        S_OUT
    } t_state;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage
`default_nettype wire

// File: hdl/xxhash64_stream_engine_top.sv
`default_nettype none
// Throughput: one word per cycle while the core is idle; a word that closes a 32-byte stripe
//   holds the core busy for eight 64-bit multiplies, the four lane rounds.
// Every multiply runs on the one shared 32x32 multiplier.
// A last word then holds the core for the multiplies of merge, tail and avalanche.
// Reset (synchronous, active low) empties the queue and clears the message state.
// ---------------------------------------------------------------------------
// xxhash64_stream_engine_top
// Streaming xxHash64: input queue in front, shared-multiplier sequencer behind.
// ---------------------------------------------------------------------------
module xxhash64_stream_engine_top #(
    parameter int QDEPTH = xxh_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_data_bytes,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last,
    input  wire logic [63:0] i_seed,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_hash_value
);
    logic           w_q_valid, w_q_pop;
    xxh_pkg::t_word w_q_word;

    xxh_front #(.DEPTH(QDEPTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_seed       (i_seed),
        .o_q_valid    (w_q_valid),
        .i_q_pop      (w_q_pop),
        .o_q_word     (w_q_word)
    );

    xxh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_word     (w_q_word),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
`default_nettype wire

// File: hdl/xxh_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// xxh_front
// Accepts input words, saturates the byte count, masks unused data bytes, queues them.
// ---------------------------------------------------------------------------
module xxh_front #(
    parameter int DEPTH = xxh_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [63:0]   i_data_bytes,
    input  wire logic [3:0]    i_byte_count,
    input  wire logic          i_last,
    input  wire logic [63:0]   i_seed,
    output logic               o_q_valid,
    input  wire logic          i_q_pop,
    output xxh_pkg::t_word     o_q_word
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    xxh_pkg::t_word r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    xxh_pkg::t_word w_word;
    logic           w_push;
    logic [3:0]     w_cnt;
    logic [63:0]    w_data;

    // non-last words and oversize counts count as a full word
    always_comb begin
        w_cnt = (!i_last || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        for (int b = 0; b < 8; b++) begin
            w_data[b*8 +: 8] = (4'(b) < w_cnt) ? i_data_bytes[b*8 +: 8] : 8'h00;
        end
        w_word.data = w_data;
        w_word.seed = i_seed;
        w_word.cnt  = w_cnt;
        w_word.last = i_last;
        w_word.full = (w_cnt == 4'd8);
    end

    assign o_ready   = (r_count != CW'(DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_word  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/xxh_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// xxh_mul
// 64x64 multiplier, low 64 bits, from three 32x32 partial products.
// ---------------------------------------------------------------------------
module xxh_mul (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_result
);
    logic        r_busy, r_done;
    logic [1:0]  r_cnt;
    logic [63:0] r_a, r_b, r_prod, r_acc;
    logic [31:0] w_x, w_y;

    always_comb begin
        unique case (r_cnt)
            2'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1:    begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_prod <= w_x * w_y;
            unique case (r_cnt)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + {r_prod[31:0], 32'h0};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

// File: hdl/xxh_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// xxh_core
// Back end: lane rounds, merge, tail rounds and avalanche over one multiplier.
// ---------------------------------------------------------------------------
module xxh_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    output logic               o_q_pop,
    input  xxh_pkg::t_word     i_q_word,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [63:0]        o_hash_value
);
    xxh_pkg::t_state r_state, n_state;

    logic [63:0] r_lane [4];
    logic [63:0] r_stripe [4];
    logic [1:0]  r_held, r_i;
    logic [63:0] r_len, r_seed, r_h, r_tmp, r_part, r_out_hash;
    logic [2:0]  r_pn;
    logic        r_inside, r_last, r_issued, r_out_valid;

    logic        w_mul_state, w_start, w_done, w_out_load;
    logic [63:0] w_a, w_b, w_prod;
    logic [1:0]  w_held_eff;
    logic [63:0] w_len_eff;

    xxh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_result(w_prod)
    );

    assign w_held_eff = r_inside ? r_held : 2'd0;
    assign w_len_eff  = r_inside ? r_len : 64'd0;
    assign w_out_load = (r_state == xxh_pkg::S_OUT) && (!r_out_valid || i_ready);

    // multiplier operands
    always_comb begin
        w_mul_state = 1'b1;
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            xxh_pkg::S_LANE_A: begin w_a = r_stripe[r_i]; w_b = xxh_pkg::P2; end
            xxh_pkg::S_LANE_B: begin w_a = r_tmp; w_b = xxh_pkg::P1; end
            xxh_pkg::S_MRG_A:  begin w_a = r_lane[r_i]; w_b = xxh_pkg::P2; end
            xxh_pkg::S_MRG_B:  begin w_a = r_tmp; w_b = xxh_pkg::P1; end
            xxh_pkg::S_MRG_C:  begin w_a = r_h; w_b = xxh_pkg::P1; end
            xxh_pkg::S_T8_A:   begin w_a = r_stripe[r_i]; w_b = xxh_pkg::P2; end
            xxh_pkg::S_T8_B:   begin w_a = r_tmp; w_b = xxh_pkg::P1; end
            xxh_pkg::S_T8_C:   begin w_a = xxh_pkg::rotl(r_h, 27); w_b = xxh_pkg::P1; end
            xxh_pkg::S_T4_A:   begin w_a = {32'h0, r_part[31:0]}; w_b = xxh_pkg::P1; end
            xxh_pkg::S_T4_B:   begin w_a = xxh_pkg::rotl(r_h, 23); w_b = xxh_pkg::P2; end
            xxh_pkg::S_T1_A:   begin w_a = {56'h0, r_part[7:0]}; w_b = xxh_pkg::P5; end
            xxh_pkg::S_T1_B:   begin w_a = xxh_pkg::rotl(r_h, 11); w_b = xxh_pkg::P1; end
            xxh_pkg::S_AV_A:   begin w_a = r_h ^ (r_h >> 33); w_b = xxh_pkg::P2; end
            xxh_pkg::S_AV_B:   begin w_a = r_h ^ (r_h >> 29); w_b = xxh_pkg::P3; end
            default:           w_mul_state = 1'b0;
        endcase
        w_start = w_mul_state && !r_issued;
        o_q_pop = (r_state == xxh_pkg::S_IDLE) && i_q_valid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            xxh_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_word.full && w_held_eff == 2'd3) begin
                        n_state = xxh_pkg::S_LANE_A;
                    end else if (i_q_word.last) begin
                        n_state = xxh_pkg::S_FIN;
                    end
                end
            end
            xxh_pkg::S_LANE_A: if (w_done) n_state = xxh_pkg::S_LANE_B;
            xxh_pkg::S_LANE_B: begin
                if (w_done) begin
                    if (r_i != 2'd3)  n_state = xxh_pkg::S_LANE_A;
                    else if (r_last)  n_state = xxh_pkg::S_FIN;
                    else              n_state = xxh_pkg::S_IDLE;
                end
            end
            xxh_pkg::S_FIN: n_state = (r_len >= 64'd32) ? xxh_pkg::S_MRG_A : xxh_pkg::S_TAIL;
            xxh_pkg::S_MRG_A: if (w_done) n_state = xxh_pkg::S_MRG_B;
            xxh_pkg::S_MRG_B: if (w_done) n_state = xxh_pkg::S_MRG_C;
            xxh_pkg::S_MRG_C: begin
                if (w_done) n_state = (r_i == 2'd3) ? xxh_pkg::S_TAIL : xxh_pkg::S_MRG_A;
            end
            xxh_pkg::S_TAIL: begin
                priority if (r_i < r_held) n_state = xxh_pkg::S_T8_A;
                else if (r_pn >= 3'd4)     n_state = xxh_pkg::S_T4_A;
                else if (r_pn != 3'd0)     n_state = xxh_pkg::S_T1_A;
                else                       n_state = xxh_pkg::S_AV_A;
            end
            xxh_pkg::S_T8_A: if (w_done) n_state = xxh_pkg::S_T8_B;
            xxh_pkg::S_T8_B: if (w_done) n_state = xxh_pkg::S_T8_C;
            xxh_pkg::S_T8_C: if (w_done) n_state = xxh_pkg::S_TAIL;
            xxh_pkg::S_T4_A: if (w_done) n_state = xxh_pkg::S_T4_B;
            xxh_pkg::S_T4_B: if (w_done) n_state = xxh_pkg::S_TAIL;
            xxh_pkg::S_T1_A: if (w_done) n_state = xxh_pkg::S_T1_B;
            xxh_pkg::S_T1_B: if (w_done) n_state = xxh_pkg::S_TAIL;
            xxh_pkg::S_AV_A: if (w_done) n_state = xxh_pkg::S_AV_B;
            xxh_pkg::S_AV_B: if (w_done) n_state = xxh_pkg::S_OUT;
            xxh_pkg::S_OUT:  if (w_out_load) n_state = xxh_pkg::S_IDLE;
            default:         n_state = xxh_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            xxh_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    if (!r_inside) begin
                        r_seed    <= i_q_word.seed;
                        r_lane[0] <= i_q_word.seed + xxh_pkg::P1 + xxh_pkg::P2;
                        r_lane[1] <= i_q_word.seed + xxh_pkg::P2;
                        r_lane[2] <= i_q_word.seed;
                        r_lane[3] <= i_q_word.seed - xxh_pkg::P1;
                    end
                    if (i_q_word.full) begin
                        r_stripe[w_held_eff] <= i_q_word.data;
                        r_pn                 <= '0;
                    end else begin
                        r_part <= i_q_word.data;
                        r_pn   <= i_q_word.cnt[2:0];
                    end
                    r_last <= i_q_word.last;
                    r_i    <= '0;
                end
            end
            xxh_pkg::S_LANE_A: if (w_done) r_tmp <= xxh_pkg::rotl(r_lane[r_i] + w_prod, 31);
            xxh_pkg::S_LANE_B: begin
                if (w_done) begin
                    r_lane[r_i] <= w_prod;
                    r_i         <= r_i + 1'b1;
                end
            end
            xxh_pkg::S_FIN: begin
                r_i <= '0;
                if (r_len >= 64'd32) begin
                    r_h <= xxh_pkg::rotl(r_lane[0], 1) + xxh_pkg::rotl(r_lane[1], 7)
                         + xxh_pkg::rotl(r_lane[2], 12) + xxh_pkg::rotl(r_lane[3], 18);
                end else begin
                    r_h <= r_seed + xxh_pkg::P5 + r_len;
                end
            end
            xxh_pkg::S_MRG_A: if (w_done) r_tmp <= xxh_pkg::rotl(w_prod, 31);
            xxh_pkg::S_MRG_B: if (w_done) r_h <= r_h ^ w_prod;
            xxh_pkg::S_MRG_C: begin
                if (w_done) begin
                    // length joins after the last lane fold
                    r_h <= w_prod + xxh_pkg::P4 + ((r_i == 2'd3) ? r_len : 64'd0);
                    r_i <= r_i + 1'b1;
                end
            end
            xxh_pkg::S_T8_A: if (w_done) r_tmp <= xxh_pkg::rotl(w_prod, 31);
            xxh_pkg::S_T8_B: if (w_done) r_h <= r_h ^ w_prod;
            xxh_pkg::S_T8_C: begin
                if (w_done) begin
                    r_h <= w_prod + xxh_pkg::P4;
                    r_i <= r_i + 1'b1;
                end
            end
            xxh_pkg::S_T4_A: if (w_done) r_h <= r_h ^ w_prod;
            xxh_pkg::S_T4_B: begin
                if (w_done) begin
                    r_h    <= w_prod + xxh_pkg::P3;
                    r_part <= r_part >> 32;
                    r_pn   <= r_pn - 3'd4;
                end
            end
            xxh_pkg::S_T1_A: if (w_done) r_h <= r_h ^ w_prod;
            xxh_pkg::S_T1_B: begin
                if (w_done) begin
                    r_h    <= w_prod;
                    r_part <= r_part >> 8;
                    r_pn   <= r_pn - 3'd1;
                end
            end
            xxh_pkg::S_AV_A: if (w_done) r_h <= w_prod;
            xxh_pkg::S_AV_B: if (w_done) r_h <= w_prod ^ (w_prod >> 32);
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_hash <= r_h;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xxh_pkg::S_IDLE;
            r_inside    <= 1'b0;
            r_held      <= '0;
            r_len       <= '0;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_issued <= 1'b1;
            end else if (w_done) begin
                r_issued <= 1'b0;
            end
            if (o_q_pop) begin
                r_inside <= 1'b1;
                if (i_q_word.full) begin
                    r_held <= w_held_eff + 1'b1;
                    r_len  <= w_len_eff + 64'd8;
                end else begin
                    r_held <= w_held_eff;
                    r_len  <= w_len_eff + 64'(i_q_word.cnt);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_inside    <= 1'b0;
                r_held      <= '0;
                r_len       <= '0;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

endmodule
`default_nettype wire

// File: hdl/xxh_chk.sv
`default_nettype none
// ---------------------------------------------------------------------------
// xxh_chk
// Port-level checks for the xxHash64 engine, bound to the top level.
// ---------------------------------------------------------------------------
module xxh_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_last,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_hash_value
);
    logic [3:0] r_pend;
    logic       w_in_last, w_out;

    assign w_in_last = i_in_valid && i_in_ready && i_last;
    assign w_out     = i_out_valid && i_out_ready;

    // last words taken but hashes not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_last && !w_out) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_in_last && w_out) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_hash_value))
        else $error("hash changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");

    a_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 4'd0)
        else $error("hash without a pending last word");

endmodule

bind xxhash64_stream_engine_top xxh_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_last       (i_last),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_hash_value (o_hash_value)
);
`default_nettype wire

// File: tb/xxhash64_stream_engine_top_tb.sv
// ---------------------------------------------------------------------------
// xxhash64_stream_engine_top_tb
// Drives whole messages into the streaming xxHash64 engine with random gaps
// and output stalls, predicts each hash in a scoreboard class, and checks
// every returned hash in order.
// ---------------------------------------------------------------------------
module xxhash64_stream_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEM_TARGET = 1450;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  DRAIN_WAIT  = 300;

    class hash_scoreboard;
        logic [63:0] lane[4];
        logic [63:0] stripe[4];
        logic [63:0] seed_q;
        logic [63:0] msg_len;
        int          held;
        bit          in_msg;
        logic [63:0] hash_q[$];
        int          errors;
        int          hashes_seen;

        function new();
            held = 0;
            msg_len = '0;
            in_msg = 0;
            errors = 0;
            hashes_seen = 0;
        endfunction

        function logic [63:0] rol(logic [63:0] x, int r);
            return (x << r) | (x >> (64 - r));
        endfunction

        function logic [63:0] lane_mix(logic [63:0] a, logic [63:0] w);
            a = a + w * xxh_pkg::P2;
            a = rol(a, 31);
            return a * xxh_pkg::P1;
        endfunction

        function int pending();
            return hash_q.size();
        endfunction

        // one accepted request: update running state, queue a hash on last
        function void note_request(logic [63:0] data, logic [3:0] cnt_in, logic last,
                                   logic [63:0] seed);
            int          cnt;
            int          pn;
            logic [63:0] part;
            logic [63:0] h;
            pn = 0;
            part = '0;
            if (!in_msg) begin
                seed_q = seed;
                lane[0] = seed + xxh_pkg::P1 + xxh_pkg::P2;
                lane[1] = seed + xxh_pkg::P2;
                lane[2] = seed;
                lane[3] = seed - xxh_pkg::P1;
                held = 0;
                msg_len = '0;
                in_msg = 1;
            end
            cnt = (!last || cnt_in > 8) ? 8 : int'(cnt_in);
            if (cnt == 8) begin
                stripe[held] = data;
                held++;
                if (held == 4) begin
                    for (int i = 0; i < 4; i++) lane[i] = lane_mix(lane[i], stripe[i]);
                    held = 0;
                end
                msg_len += 8;
            end else begin
                part = (cnt == 0) ? 64'd0 : data & ((64'd1 << (8 * cnt)) - 64'd1);
                pn = cnt;
                msg_len += cnt;
            end
            if (!last) return;

            // length wraps at 2^64; the merge choice follows the wrapped value
            if (msg_len >= 32) begin
                h = rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18);
                for (int i = 0; i < 4; i++)
                    h = (h ^ lane_mix('0, lane[i])) * xxh_pkg::P1 + xxh_pkg::P4;
            end else begin
                h = seed_q + xxh_pkg::P5;
            end
            h += msg_len;
            for (int i = 0; i < held; i++) begin
                h ^= lane_mix('0, stripe[i]);
                h = rol(h, 27) * xxh_pkg::P1 + xxh_pkg::P4;
            end
            if (pn >= 4) begin
                h ^= (part & 64'hFFFF_FFFF) * xxh_pkg::P1;
                h = rol(h, 23) * xxh_pkg::P2 + xxh_pkg::P3;
                part >>= 32;
                pn -= 4;
            end
            while (pn > 0) begin
                h ^= (part & 64'hFF) * xxh_pkg::P5;
                h = rol(h, 11) * xxh_pkg::P1;
                part >>= 8;
                pn--;
            end
            h ^= h >> 33;
            h *= xxh_pkg::P2;
            h ^= h >> 29;
            h *= xxh_pkg::P3;
            h ^= h >> 32;
            hash_q.push_back(h);
            in_msg = 0;
            held = 0;
            msg_len = '0;
        endfunction

        function void check_hash(logic [63:0] actual, realtime t);
            logic [63:0] exp_h;
            hashes_seen++;
            if (hash_q.size() == 0) begin
                $display("%0t: unexpected hash %h", t, actual);
                errors++;
                return;
            end
            exp_h = hash_q.pop_front();
            if (actual !== exp_h) begin
                $display("%0t: hash mismatch expected %h actual %h", t, exp_h, actual);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_data_bytes;
    logic [3:0]  i_byte_count;
    logic        i_last;
    logic [63:0] i_seed;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_hash_value;

    hash_scoreboard sb;
    int  words_sent;
    int  msgs_sent;
    int  cycles;
    int  hold_cnt;
    bit  no_idle;
    bit  rst_done;

    xxhash64_stream_engine_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_seed       (i_seed),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hash_value (o_hash_value)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("xxhash64_stream_engine_top_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_done && o_out_valid && i_out_ready) sb.check_hash(o_hash_value, $realtime);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // output side: random stalls, plus a long counted hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b0;
        wait (rst_done);
        forever begin
            @(negedge i_clk);
            if (hold_cnt > 0) begin
                i_out_ready = 1'b0;
                hold_cnt--;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_word(logic [63:0] data, logic [3:0] cnt, logic last, logic [63:0] seed);
        int gap;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_data_bytes = data;
        i_byte_count = cnt;
        i_last       = last;
        i_seed       = seed;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(data, cnt, last, seed);
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // nfull full words, then a last word carrying last_cnt
    task automatic send_message(int nfull, logic [3:0] last_cnt, logic [63:0] seed);
        for (int i = 0; i < nfull; i++)
            send_word(rand64(), 4'($urandom_range(0, 15)), 1'b0, i == 0 ? seed : rand64());
        send_word(rand64(), last_cnt, 1'b1, nfull == 0 ? seed : rand64());
        msgs_sent++;
    endtask

    initial begin
        int  r;
        bit  held_off;
        bit  paused;
        logic [63:0] sd;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_data_bytes = '0;
        i_byte_count = '0;
        i_last = 1'b0;
        i_seed = '0;
        cycles = 0;
        hold_cnt = 0;
        no_idle = 0;
        rst_done = 0;
        words_sent = 0;
        msgs_sent = 0;
        held_off = 0;
        paused = 0;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1;

        // directed: empty message, byte counts 1 to 8 and the saturating counts 9 and 15
        send_word('0, 4'd0, 1'b1, '0);
        for (int c = 1; c <= 8; c++)
            send_word({64{1'b1}}, 4'(c), 1'b1, c[0] ? {64{1'b1}} : 64'h5555_aaaa_5555_aaaa);
        send_word(64'h0123_4567_89ab_cdef, 4'd9, 1'b1, '0);
        send_word({64{1'b1}}, 4'd15, 1'b1, {64{1'b1}});
        msgs_sent += 11;
        // around the 32-byte boundary
        send_message(3, 4'd7, {64{1'b1}});
        send_message(3, 4'd8, '0);
        send_message(4, 4'd1, 64'h8000_0000_0000_0001);

        while (words_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 2) no_idle = ~no_idle;
            if (!held_off && words_sent > 500) begin
                // long output hold-off while input keeps coming
                held_off = 1;
                hold_cnt = 600;
                for (int k = 0; k < 6; k++) send_message($urandom_range(0, 2), 4'd3, rand64());
            end
            if (!paused && words_sent > 900) begin
                paused = 1;
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            r = $urandom_range(0, 99);
            sd = (r < 5) ? '0 : (r < 10) ? {64{1'b1}} : rand64();
            if ($urandom_range(0, 99) < 85)
                send_message($urandom_range(0, 9), 4'($urandom_range(0, 15)), sd);
            else
                send_message($urandom_range(10, 24), 4'($urandom_range(0, 15)), sd);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d words in %0d messages sent, %0d hashes returned and compared",
                 words_sent, msgs_sent, sb.hashes_seen);
        $display("covered empty and partial tails, stripe merges, output hold-off and pause");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("xxhash64_stream_engine_top_tb: done, clean");
        end else begin
            $display("xxhash64_stream_engine_top_tb: done, errors");
        end
        $finish;
    end

endmodule
